@@ hw/rtl/scripted_input_playback_sequencer_core_macros.svh @@
// Assertion macros for the playback sequencer.
`ifndef SCRIPTED_INPUT_PLAYBACK_SEQUENCER_CORE_MACROS_SVH
`define SCRIPTED_INPUT_PLAYBACK_SEQUENCER_CORE_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define SIPS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Implication checked even during reset.
`define SIPS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`endif

@@ hw/rtl/sips_pkg.sv @@
// Package: constants, codes and types of the playback sequencer.
package sips_pkg;
    localparam int MaxSteps = 64;
    localparam int IdxW = $clog2(MaxSteps);
    localparam int CntW = IdxW + 1;
    localparam int EntryW = 25;

    typedef enum logic [3:0] {
        F_CLEAR = 4'd0, F_APPEND = 4'd1, F_START = 4'd2, F_STOP = 4'd3,
        F_RESET = 4'd4, F_TICK = 4'd5, F_SAMPLE = 4'd6, F_REPORT = 4'd7,
        F_MBEGIN = 4'd8, F_MEND = 4'd9
    } t_func;

    localparam logic [1:0] KIND_STOP = 2'd2;
    localparam logic [1:0] MODE_MERGE = 2'd1;
    localparam logic [1:0] MODE_TRIG = 2'd2;
    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] REG_MODE = 2'd0;
    localparam logic [1:0] REG_TMASK = 2'd1;
    localparam logic [1:0] REG_SLOW = 2'd2;
endpackage

@@ hw/rtl/sips_ram.sv @@
// Generic single-port-write, registered-read RAM.
module sips_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

@@ hw/rtl/scripted_input_playback_sequencer_core.sv @@
// Top level of the scripted input playback sequencer.
// Usage: one request per item on the slave stream yields one result on the
// master stream. A request is captured at the accepting edge and executed in
// the next cycle, and the result register loads at the edge that ends it.
// s_axis_tready is low while a request is in work. A tick that must enter a
// new script step walks the command RAM one entry at a time (registered RAM
// read, then a check) to skip zero-length commands; the walk reads at most 64
// entries, and a walk that runs off the end of the list ends the run.
// The block takes one request at a time: s_axis_tready is high only when no
// request is in work and the result register is free or being drained. No
// clearing pass runs after reset; the command RAM is only read below the fill
// count. Configuration registers are written on the plain write port; write
// them only while no request is in work.
module scripted_input_playback_sequencer_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata from bit 0: func[4], cmd_kind[2], cmd_buttons[7], cmd_frames[16],
    // phys_buttons[6], frame_time_us[24], skipped_count[8], zero pad[5]
    input  logic [71:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata from bit 0: buttons_out[6], is_running, is_finished, status[2],
    // report_due, tick_count[32], report_count[32], slow_count[32],
    // skipped_total[32], elapsed_us[40], best_us[24], worst_us[24], pad[5]
    output logic [231:0] m_axis_tdata
);
    import sips_pkg::*;
    `include "scripted_input_playback_sequencer_core_macros.svh"

    typedef enum logic [1:0] {S_IDLE, S_EXEC, S_READ, S_CHECK} t_state;

    t_state r_state;
    logic [1:0]  r_mode;
    logic [5:0]  r_tmask;
    logic [23:0] r_slow;
    logic [71:0] r_req;
    logic [CntW-1:0] r_count, r_step;
    logic [15:0] r_frem;
    logic r_need, r_run, r_fin, r_arm, r_pend, r_meas;
    logic [6:0]  r_act;
    logic [31:0] r_tot, r_mcnt, r_scnt, r_skip;
    logic [39:0] r_sum;
    logic [23:0] r_best, r_worst;
    logic [5:0]  r_bout;
    logic [1:0]  r_status;
    logic r_rep, r_ovalid;

    logic [EntryW-1:0] w_rdata;
    t_func w_func;
    logic [1:0]  w_kind;
    logic [6:0]  w_cbtn;
    logic [15:0] w_cfr;
    logic [5:0]  w_real;
    logic [23:0] w_ft;
    logic [7:0]  w_sk;
    logic w_we;
    logic [32:0] w_skadd;
    logic [40:0] w_sumadd;

    assign w_func = t_func'(r_req[3:0]);
    assign w_kind = r_req[5:4];
    assign w_cbtn = r_req[12:6];
    assign w_cfr  = r_req[28:13];
    assign w_real = r_req[34:29];
    assign w_ft   = r_req[58:35];
    assign w_sk   = r_req[66:59];
    assign w_we = (r_state == S_EXEC) && (w_func == F_APPEND) &&
                  (r_count < CntW'(MaxSteps));
    assign w_skadd = {1'b0, r_skip} + {25'd0, w_sk};
    assign w_sumadd = {1'b0, r_sum} + {17'd0, w_ft};

    sips_ram #(.Width(EntryW), .Depth(MaxSteps)) u_store (
        .i_clk(i_clk),
        .i_we(w_we),
        .i_waddr(r_count[IdxW-1:0]),
        .i_wdata({w_kind, w_cbtn, w_cfr}),
        .i_raddr(r_step[IdxW-1:0]),
        .o_rdata(w_rdata)
    );

    assign s_axis_tready = (r_state == S_IDLE) && (!r_ovalid || m_axis_tready);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata = {5'd0, r_worst, r_best, r_sum, r_skip, r_scnt, r_mcnt,
                           r_tot, r_rep, r_status, r_fin, r_run, r_bout};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= '0;
            r_tmask <= 6'd16;
            r_slow <= 24'd20000;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_MODE:  r_mode <= i_cfg_data[1:0];
                REG_TMASK: r_tmask <= i_cfg_data[5:0];
                REG_SLOW:  r_slow <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Sequencer: one clocked block holds state, script state and statistics.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ovalid <= 1'b0;
            r_count <= '0; r_step <= '0; r_frem <= '0;
            r_need <= 1'b1; r_run <= 1'b0; r_fin <= 1'b0; r_arm <= 1'b0;
            r_pend <= 1'b0; r_meas <= 1'b0; r_act <= '0;
            r_tot <= '0; r_mcnt <= '0; r_scnt <= '0; r_skip <= '0;
            r_sum <= '0; r_best <= '0; r_worst <= '0;
            r_bout <= '0; r_status <= ST_OK; r_rep <= 1'b0;
        end else begin
            if (r_ovalid && m_axis_tready) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid && s_axis_tready) begin
                        r_req <= s_axis_tdata;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_bout <= '0; r_status <= ST_OK; r_rep <= 1'b0;
                    r_state <= S_IDLE;
                    r_ovalid <= 1'b1;
                    unique case (w_func)
                        F_CLEAR, F_RESET: begin
                            if (w_func == F_CLEAR) r_count <= '0;
                            r_step <= '0; r_frem <= '0; r_need <= 1'b1;
                            r_run <= 1'b0; r_fin <= 1'b0; r_arm <= 1'b0;
                            r_pend <= 1'b0; r_meas <= 1'b0; r_act <= '0;
                            r_tot <= '0; r_mcnt <= '0; r_scnt <= '0; r_skip <= '0;
                            r_sum <= '0; r_best <= '0; r_worst <= '0;
                        end
                        F_APPEND: begin
                            if (w_we) r_count <= r_count + 1'b1;
                            else r_status <= ST_FULL;
                        end
                        F_START: begin
                            if (r_count == '0) begin
                                r_status <= ST_EMPTY;
                            end else begin
                                r_step <= '0; r_frem <= '0; r_need <= 1'b1;
                                r_fin <= 1'b0; r_pend <= 1'b0; r_act <= '0;
                                r_tot <= '0; r_mcnt <= '0; r_scnt <= '0;
                                r_skip <= '0; r_sum <= '0; r_best <= '0;
                                r_worst <= '0;
                                r_run <= (r_mode != MODE_TRIG);
                                r_arm <= (r_mode == MODE_TRIG);
                                r_meas <= (r_mode != MODE_TRIG);
                            end
                        end
                        F_STOP: begin
                            if (r_run || r_arm) begin
                                r_run <= 1'b0; r_arm <= 1'b0; r_pend <= 1'b0;
                                r_meas <= 1'b0; r_act <= '0; r_fin <= 1'b1;
                            end
                        end
                        F_TICK: begin
                            priority if (r_pend) begin
                                if (r_run || r_arm) begin
                                    r_run <= 1'b0; r_arm <= 1'b0; r_pend <= 1'b0;
                                    r_meas <= 1'b0; r_act <= '0; r_fin <= 1'b1;
                                    r_rep <= 1'b1;
                                end
                            end else if (!r_run) begin
                            end else if (r_need) begin
                                // step-entry walk over the command RAM
                                r_ovalid <= 1'b0;
                                r_state <= S_READ;
                            end else begin
                                if (r_tot != '1) r_tot <= r_tot + 1'b1;
                                if (r_frem <= 16'd1) begin
                                    r_frem <= '0;
                                    r_step <= r_step + 1'b1;
                                    r_need <= 1'b1;
                                    if (r_step + 1'b1 >= r_count) r_pend <= 1'b1;
                                end else begin
                                    r_frem <= r_frem - 1'b1;
                                end
                            end
                        end
                        F_SAMPLE: begin
                            if (r_arm && (w_real & r_tmask) != '0) begin
                                r_step <= '0; r_frem <= '0; r_need <= 1'b1;
                                r_run <= 1'b1; r_fin <= 1'b0; r_arm <= 1'b0;
                                r_pend <= 1'b0; r_act <= '0; r_meas <= 1'b1;
                                r_tot <= '0; r_mcnt <= '0; r_scnt <= '0;
                                r_skip <= '0; r_sum <= '0; r_best <= '0;
                                r_worst <= '0;
                                r_bout <= (r_mode == MODE_MERGE) ? w_real : 6'd0;
                            end else if (!r_run) r_bout <= w_real;
                            else if (r_mode == MODE_MERGE) r_bout <= w_real | r_act[5:0];
                            else r_bout <= r_act[5:0];
                        end
                        F_REPORT: begin
                            if (r_run && r_meas) begin
                                if (r_mcnt != '1) r_mcnt <= r_mcnt + 1'b1;
                                r_sum <= w_sumadd[40] ? '1 : w_sumadd[39:0];
                                r_skip <= w_skadd[32] ? '1 : w_skadd[31:0];
                                if (r_mcnt == '0 || w_ft < r_best) r_best <= w_ft;
                                if (r_mcnt == '0 || w_ft > r_worst) r_worst <= w_ft;
                                if (w_ft > r_slow && r_scnt != '1)
                                    r_scnt <= r_scnt + 1'b1;
                                if (r_pend) begin
                                    r_run <= 1'b0; r_arm <= 1'b0; r_pend <= 1'b0;
                                    r_meas <= 1'b0; r_act <= '0; r_fin <= 1'b1;
                                    r_rep <= 1'b1;
                                end
                            end
                        end
                        F_MBEGIN: begin
                            r_mcnt <= '0; r_scnt <= '0; r_skip <= '0;
                            r_sum <= '0; r_best <= '0; r_worst <= '0;
                            r_meas <= 1'b1;
                        end
                        F_MEND: r_meas <= 1'b0;
                        default: ;
                    endcase
                end
                S_READ: begin
                    if (r_step >= r_count) begin
                        // ran off the end of the list
                        r_run <= 1'b0; r_arm <= 1'b0; r_pend <= 1'b0;
                        r_meas <= 1'b0; r_act <= '0; r_fin <= 1'b1;
                        r_rep <= 1'b1; r_ovalid <= 1'b1; r_state <= S_IDLE;
                    end else begin
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (w_rdata[24:23] == KIND_STOP) begin
                        r_run <= 1'b0; r_arm <= 1'b0; r_pend <= 1'b0;
                        r_meas <= 1'b0; r_act <= '0; r_fin <= 1'b1;
                        r_rep <= 1'b1; r_ovalid <= 1'b1; r_state <= S_IDLE;
                    end else if (w_rdata[15:0] == '0) begin
                        r_step <= r_step + 1'b1;
                        r_state <= S_READ;
                    end else begin
                        // step entered, then the tick proper
                        r_act <= w_rdata[22:16];
                        r_need <= 1'b0;
                        if (r_tot != '1) r_tot <= r_tot + 1'b1;
                        if (w_rdata[15:0] == 16'd1) begin
                            r_frem <= '0;
                            r_step <= r_step + 1'b1;
                            r_need <= 1'b1;
                            if (r_step + 1'b1 >= r_count) r_pend <= 1'b1;
                        end else begin
                            r_frem <= w_rdata[15:0] - 1'b1;
                        end
                        r_ovalid <= 1'b1; r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `SIPS_ASSERT(a_no_run_and_arm, i_clk, i_rst_n, !(r_run && r_arm), "run and arm both set")
    `SIPS_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CntW'(MaxSteps), "fill count overflow")
    `SIPS_ASSERT(a_busy_no_ready, i_clk, i_rst_n, (r_state != S_IDLE) |-> !s_axis_tready, "ready while busy")
    `SIPS_ASSERT(a_walk_no_result, i_clk, i_rst_n, (r_state == S_READ) |-> !r_ovalid, "result during walk")
endmodule

@@ verif/testbench.sv @@
// Stream testbench for the scripted input playback sequencer core.
module testbench;
    import sips_pkg::*;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_cfg_we;
    logic [1:0]   i_cfg_index;
    logic [23:0]  i_cfg_data;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [71:0]  s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [231:0] m_axis_tdata;

    scripted_input_playback_sequencer_core uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    localparam int CYCLE_LIMIT = 2000000;

    // Predictor state: mirrors the sequencer's architectural state.
    logic [1:0]  mode_q;
    logic [5:0]  tmask_q;
    logic [23:0] slow_q;
    logic [24:0] cmd_mem [MaxSteps];
    int unsigned fill_cnt, step_idx;
    logic [15:0] frames_left;
    bit need_enter, running, finished, armed, pend_stop, measuring, rpt_flag;
    logic [6:0]  active_btn;
    logic [31:0] total_cnt, meas_cnt, slow_cnt, skip_cnt;
    logic [39:0] elapsed_sum;
    logic [23:0] best_t, worst_t;

    logic [71:0]  pending_reqs[$];
    logic [231:0] expected_results[$];

    int  cycle_cnt;
    int  errors;
    int  src_idle_pct, dst_idle_pct;
    bit  hold_start, hold_on;
    bit  driver_on;

    function automatic logic [31:0] sat32(logic [31:0] a, logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function automatic void clear_stats();
        total_cnt = '0; meas_cnt = '0; slow_cnt = '0; skip_cnt = '0;
        elapsed_sum = '0; best_t = '0; worst_t = '0;
    endfunction

    function automatic void reset_runtime();
        step_idx = 0; frames_left = '0; need_enter = 1'b1; running = 1'b0;
        finished = 1'b0; armed = 1'b0; pend_stop = 1'b0; measuring = 1'b0;
        active_btn = '0;
        clear_stats();
    endfunction

    function automatic void end_run(bit automatic_end);
        if (!running && !armed) return;
        running = 1'b0; armed = 1'b0; pend_stop = 1'b0; measuring = 1'b0;
        active_btn = '0; finished = 1'b1;
        if (automatic_end) rpt_flag = 1'b1;
    endfunction

    function automatic void begin_now();
        step_idx = 0; frames_left = '0; need_enter = 1'b1; running = 1'b1;
        finished = 1'b0; armed = 1'b0; pend_stop = 1'b0; active_btn = '0;
        measuring = 1'b1;
        clear_stats();
    endfunction

    // Walk the script from step_idx, skipping zero-length commands.
    function automatic void enter_step();
        logic [24:0] e;
        while (step_idx < fill_cnt) begin
            e = cmd_mem[step_idx];
            if (e[24:23] == KIND_STOP) begin
                end_run(1'b1);
                return;
            end
            if (e[15:0] == '0) begin
                step_idx++;
                continue;
            end
            active_btn = e[22:16];
            frames_left = e[15:0];
            need_enter = 1'b0;
            return;
        end
        end_run(1'b1);
    endfunction

    function automatic void frame_tick();
        if (pend_stop) begin
            end_run(1'b1);
            return;
        end
        if (!running) return;
        if (need_enter) begin
            enter_step();
            if (!running) return;
        end
        total_cnt = sat32(total_cnt, 32'd1);
        if (frames_left > 0) frames_left--;
        if (frames_left == 0) begin
            step_idx++;
            need_enter = 1'b1;
            if (step_idx >= fill_cnt) pend_stop = 1'b1;
        end
    endfunction

    function automatic void frame_report(logic [23:0] t, logic [7:0] sk);
        logic [40:0] s;
        if (!running || !measuring) return;
        meas_cnt = sat32(meas_cnt, 32'd1);
        s = {1'b0, elapsed_sum} + {17'd0, t};
        elapsed_sum = s[40] ? 40'hFF_FFFF_FFFF : s[39:0];
        skip_cnt = sat32(skip_cnt, {24'd0, sk});
        if (meas_cnt == 1 || t < best_t) best_t = t;
        if (meas_cnt == 1 || t > worst_t) worst_t = t;
        if (t > slow_q) slow_cnt = sat32(slow_cnt, 32'd1);
        if (pend_stop) end_run(1'b1);
    endfunction

    // Compute the result of one request and update the predictor state.
    function automatic logic [231:0] sequencer_result(logic [71:0] d);
        logic [3:0]  fn;
        logic [5:0]  real_b, bout;
        logic [1:0]  st;
        fn = d[3:0]; real_b = d[34:29]; bout = '0; st = ST_OK;
        rpt_flag = 1'b0;
        case (fn)
            F_CLEAR: begin
                fill_cnt = 0;
                reset_runtime();
            end
            F_APPEND: begin
                if (fill_cnt >= MaxSteps) st = ST_FULL;
                else begin
                    cmd_mem[fill_cnt] = {d[5:4], d[12:6], d[28:13]};
                    fill_cnt++;
                end
            end
            F_START: begin
                if (fill_cnt == 0) st = ST_EMPTY;
                else if (mode_q == MODE_TRIG) begin
                    clear_stats();
                    step_idx = 0; frames_left = '0; need_enter = 1'b1;
                    running = 1'b0; finished = 1'b0; armed = 1'b1;
                    pend_stop = 1'b0; measuring = 1'b0; active_btn = '0;
                end else begin
                    begin_now();
                end
            end
            F_STOP:   end_run(1'b0);
            F_RESET:  reset_runtime();
            F_TICK:   frame_tick();
            F_SAMPLE: begin
                if (armed && (real_b & tmask_q) != '0) begin_now();
                if (!running) bout = real_b;
                else if (mode_q == MODE_MERGE) bout = real_b | active_btn[5:0];
                else bout = active_btn[5:0];
            end
            F_REPORT: frame_report(d[58:35], d[66:59]);
            F_MBEGIN: begin
                meas_cnt = '0; slow_cnt = '0; skip_cnt = '0; elapsed_sum = '0;
                best_t = '0; worst_t = '0; measuring = 1'b1;
            end
            F_MEND:   measuring = 1'b0;
            default: ;
        endcase
        return {5'd0, worst_t, best_t, elapsed_sum, skip_cnt, slow_cnt, meas_cnt,
                total_cnt, rpt_flag, st, finished, running, bout};
    endfunction

    function automatic logic [71:0] pack_req(logic [3:0] fn, logic [1:0] kind,
            logic [6:0] cb, logic [15:0] cf, logic [5:0] rb, logic [23:0] ft,
            logic [7:0] sk);
        return {5'd0, sk, ft, rb, cf, cb, kind, fn};
    endfunction

    // Random request of the given function with random content on every other field.
    function automatic logic [71:0] rand_req(logic [3:0] fn);
        return pack_req(fn, 2'($urandom_range(0, 3)), 7'($urandom_range(0, 127)),
                        $urandom_range(0, 3) == 0 ? 16'($urandom_range(0, 1)) :
                        ($urandom_range(0, 9) == 0 ? 16'($urandom) :
                         16'($urandom_range(0, 4))),
                        6'($urandom_range(0, 63)),
                        $urandom_range(0, 7) == 0 ? 24'($urandom) :
                        24'($urandom_range(10000, 30000)),
                        8'($urandom_range(0, 255)));
    endfunction

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // Cycle counter and timeout.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Long receiver hold-off, counted in its own process.
    initial begin
        wait (hold_start);
        @(posedge i_clk);
        hold_on <= 1'b1;
        repeat (400) @(posedge i_clk);
        hold_on <= 1'b0;
    end

    // Driver: present queued requests, predict on acceptance.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            fill_cnt = 0;
            rpt_flag = 1'b0;
            reset_runtime();
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                expected_results.push_back(sequencer_result(s_axis_tdata));
                void'(pending_reqs.pop_front());
            end
            if (s_axis_tvalid && !s_axis_tready) begin
                // hold request until accepted
            end else if (driver_on && pending_reqs.size() > 0
                         && $urandom_range(0, 99) >= src_idle_pct) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= pending_reqs[0];
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: random backpressure, long hold-off, compare results in order.
    always @(posedge i_clk) begin
        logic [231:0] exp_r;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t unexpected result act=%h", $time, m_axis_tdata);
                    errors <= errors + 1;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (exp_r !== m_axis_tdata) begin
                        $display("%0t mismatch exp=%h act=%h", $time, exp_r,
                                 m_axis_tdata);
                        errors <= errors + 1;
                    end
                end
            end
            if (hold_on) begin
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(0, 99) >= dst_idle_pct);
            end
        end
    end

    task automatic wait_drained();
        while (pending_reqs.size() != 0 || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [23:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1; i_cfg_index <= idx; i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_MODE:  mode_q  = val[1:0];
            REG_TMASK: tmask_q = val[5:0];
            default:   slow_q  = val;
        endcase
    endtask

    // Script run: clear, build, start, then mostly tick/sample/report.
    task automatic queue_run(int len);
        int n;
        pending_reqs.push_back(pack_req(F_CLEAR, 0, 0, 0, 0, 0, 0));
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++) pending_reqs.push_back(rand_req(F_APPEND));
        pending_reqs.push_back(rand_req(F_START));
        for (int i = 0; i < len; i++) begin
            case ($urandom_range(0, 11))
                0, 1, 2, 3: pending_reqs.push_back(rand_req(F_TICK));
                4, 5, 6:    pending_reqs.push_back(rand_req(F_SAMPLE));
                7, 8:       pending_reqs.push_back(rand_req(F_REPORT));
                9:          pending_reqs.push_back(rand_req(4'($urandom_range(8, 9))));
                10:         pending_reqs.push_back(rand_req(4'($urandom_range(0, 15))));
                default:    pending_reqs.push_back(rand_req(F_STOP));
            endcase
        end
    endtask

    task automatic random_phase(int items);
        driver_on = 1;
        repeat (items / 20) queue_run(14);
        wait_drained();
    endtask

    initial begin
        i_rst_n = 0; i_cfg_we = 0; i_cfg_index = 0; i_cfg_data = 0;
        driver_on = 0;
        src_idle_pct = 0; dst_idle_pct = 0;
        mode_q = 0; tmask_q = 16; slow_q = 20000;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: empty start, zero-length skip, stop command, full store.
        src_idle_pct = 11; dst_idle_pct = 51;
        driver_on = 1;
        pending_reqs.push_back(pack_req(F_START, 0, 0, 0, 0, 0, 0));
        pending_reqs.push_back(pack_req(F_SAMPLE, 0, 0, 0, 6'h3F, 0, 0));
        pending_reqs.push_back(pack_req(F_APPEND, 0, 7'h7F, 0, 0, 0, 0));
        pending_reqs.push_back(pack_req(F_APPEND, 3, 7'h7F, 2, 0, 0, 0));
        pending_reqs.push_back(pack_req(F_APPEND, 1, 7'h2A, 16'hFFFF, 0, 0, 0));
        pending_reqs.push_back(pack_req(F_APPEND, 2, 0, 5, 0, 0, 0));
        pending_reqs.push_back(pack_req(F_START, 0, 0, 0, 0, 0, 0));
        pending_reqs.push_back(pack_req(F_TICK, 0, 0, 0, 0, 0, 0));
        pending_reqs.push_back(pack_req(F_SAMPLE, 0, 0, 0, 6'h15, 0, 0));
        pending_reqs.push_back(pack_req(F_REPORT, 0, 0, 0, 0, 24'hFFFFFF, 8'hFF));
        pending_reqs.push_back(pack_req(F_REPORT, 0, 0, 0, 0, 0, 0));
        pending_reqs.push_back(pack_req(F_TICK, 0, 0, 0, 0, 0, 0));
        pending_reqs.push_back(pack_req(F_MEND, 0, 0, 0, 0, 0, 0));
        pending_reqs.push_back(pack_req(F_REPORT, 0, 0, 0, 0, 5, 1));
        pending_reqs.push_back(pack_req(F_MBEGIN, 0, 0, 0, 0, 0, 0));
        pending_reqs.push_back(pack_req(4'd15, 0, 0, 0, 0, 0, 0));
        pending_reqs.push_back(pack_req(F_STOP, 0, 0, 0, 0, 0, 0));
        pending_reqs.push_back(pack_req(F_STOP, 0, 0, 0, 0, 0, 0));
        pending_reqs.push_back(pack_req(F_RESET, 0, 0, 0, 0, 0, 0));
        for (int i = 0; i < 62; i++)
            pending_reqs.push_back(pack_req(F_APPEND, 0, 0, 0, 0, 0, 0));
        pending_reqs.push_back(pack_req(F_START, 0, 0, 0, 0, 0, 0));
        pending_reqs.push_back(pack_req(F_TICK, 0, 0, 0, 0, 0, 0));
        pending_reqs.push_back(pack_req(F_TICK, 0, 0, 0, 0, 0, 0));
        wait_drained();

        // Manual trigger mode, threshold extremes, long receiver hold-off.
        write_reg(REG_MODE, MODE_TRIG);
        write_reg(REG_TMASK, 6'h3F);
        write_reg(REG_SLOW, 24'd0);
        src_idle_pct = 11; dst_idle_pct = 51;
        hold_start = 1;
        random_phase(260);

        write_reg(REG_MODE, MODE_MERGE);
        write_reg(REG_TMASK, 6'h00);
        write_reg(REG_SLOW, 24'hFFFFFF);
        src_idle_pct = 51; dst_idle_pct = 11;
        random_phase(240);

        write_reg(REG_MODE, 2'd3);
        write_reg(REG_TMASK, 6'h10);
        write_reg(REG_SLOW, 24'd20000);
        src_idle_pct = 0; dst_idle_pct = 0;
        random_phase(240);

        write_reg(REG_MODE, MODE_TRIG);
        write_reg(REG_TMASK, 6'h05);
        random_phase(80);

        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
